// ----- rtl/lsrc_pkg.sv -----
// shared types, constants and outcode function for the segment clipper
package lsrc_pkg;

  localparam int COORD_BITS = 32;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 64;
  localparam int ADDR_BITS  = 4;
  localparam int MAX_PASSES = 4;
  localparam int PASS_BITS  = 3;

  localparam logic [3:0] OC_INSIDE = 4'h0;
  localparam logic [3:0] OC_LEFT   = 4'h1;
  localparam logic [3:0] OC_RIGHT  = 4'h2;
  localparam logic [3:0] OC_BOTTOM = 4'h4;
  localparam logic [3:0] OC_TOP    = 4'h8;

  localparam logic [1:0] REG_A_X = 2'd0;
  localparam logic [1:0] REG_A_Y = 2'd1;
  localparam logic [1:0] REG_B_X = 2'd2;
  localparam logic [1:0] REG_B_Y = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_t;

  typedef struct packed {
    logic [1:0] point_count;
    coord_t     first_x;
    coord_t     first_y;
    coord_t     second_x;
    coord_t     second_y;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CODE, ST_SETUP, ST_MUL, ST_ABS, ST_DIV, ST_FIN, ST_DONE
  } state_t;

  function automatic logic [3:0] outcode(coord_t x, coord_t y, coord_t l, coord_t r,
                                         coord_t b, coord_t t);
    logic [3:0] c;
    c = OC_INSIDE;
    if (x < l) c = c | OC_LEFT;
    else if (x > r) c = c | OC_RIGHT;
    if (y < b) c = c | OC_BOTTOM;
    else if (y > t) c = c | OC_TOP;
    return c;
  endfunction

endpackage

// ----- rtl/lsrc_div.sv -----
// unsigned restoring divider, two quotient bits per cycle
module lsrc_div import lsrc_pkg::*; #(
  parameter int NUM_BITS = PROD_BITS,
  parameter int DEN_BITS = DIFF_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic [NUM_BITS-1:0] quo,
  output logic                done
);

  localparam int REM_BITS = DEN_BITS + 1;
  localparam int STEPS    = NUM_BITS / 2;
  localparam int CNT_BITS = $clog2(STEPS);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(STEPS - 1);

  logic [REM_BITS-1:0] rem_r;
  logic [NUM_BITS-1:0] quo_r;
  logic [DEN_BITS-1:0] den_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [REM_BITS+NUM_BITS-1:0] s1, s2;

  function automatic logic [REM_BITS+NUM_BITS-1:0] step(logic [REM_BITS-1:0] rm,
                                                        logic [NUM_BITS-1:0] qu,
                                                        logic [DEN_BITS-1:0] dv);
    logic [REM_BITS-1:0] tr;
    logic                bit_q;
    tr = {rm[REM_BITS-2:0], qu[NUM_BITS-1]};
    bit_q = (tr >= {1'b0, dv});
    if (bit_q) tr = tr - {1'b0, dv};
    return {tr, qu[NUM_BITS-2:0], bit_q};
  endfunction

  always_comb begin
    s1 = step(rem_r, quo_r, den_r);
    s2 = step(s1[REM_BITS+NUM_BITS-1:NUM_BITS], s1[NUM_BITS-1:0], den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= s2[REM_BITS+NUM_BITS-1:NUM_BITS];
      quo_r <= s2[NUM_BITS-1:0];
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ----- rtl/line_segment_rect_clip.sv -----
// segment clipper against a configured rectangle, outcode based, shared divider
//
// usage: write the two rectangle corners through the apb port while idle,
// word addresses 0x0 a_x, 0x4 a_y, 0x8 b_x, 0xc b_y, reads return them.
// an item on in_data is taken when in_valid is high and in_stall low.
// in_stall stays high while an item is being worked on.
// each item gives exactly one result item on out_data.
// a segment that needs no clip pass goes from accept through code and setup to the result;
// each clip pass runs again from setup, at most four passes;
// the next item is taken in the cycle after the result loads.
// the pass time is set by the shared divider, which takes its 64-bit dividend
// at two quotient bits a cycle, plus setup, multiply, magnitude and update.
// the result sits in an output register: a stalled receiver holds it,
// and the next item is accepted meanwhile; a finished item waits until the
// output register frees up.
// reset clears the corners to zero and empties the block.
module line_segment_rect_clip import lsrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [COORD_BITS-1:0] pwdata,
  output logic [COORD_BITS-1:0] prdata,
  output logic                  pready
);

  localparam int C = COORD_BITS;
  localparam int W = DIFF_BITS;

  state_t state_r, state_nxt;

  coord_t ax_r, ay_r, bx_r, by_r;
  coord_t l, r, b, t;
  coord_t x0_r, y0_r, x1_r, y1_r;
  logic [3:0] c0_r, c1_r, co;
  logic [PASS_BITS-1:0] pass_r;
  logic [1:0] n_r;
  coord_t px_r [2];
  coord_t py_r [2];

  coord_t a_r, fix_r;
  logic signed [W-1:0] da_r, dm_r, db_r;
  logic vert_r, sel0_r;
  logic [PROD_BITS-1:0] p_r, pmag;
  logic signed [2*W-1:0] prod;
  logic [W-1:0] dmag;
  logic qneg_r, dzero_r;

  logic div_start, div_done;
  logic [PROD_BITS-1:0] quo;
  logic finish, acc, out_free;
  coord_t qadd, sum, nx, ny;
  logic [3:0] nc;

  out_t out_r;
  logic out_valid_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0; ay_r <= '0; bx_r <= '0; by_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_A_X: ax_r <= pwdata;
        REG_A_Y: ay_r <= pwdata;
        REG_B_X: bx_r <= pwdata;
        REG_B_Y: by_r <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_A_X: prdata = ax_r;
      REG_A_Y: prdata = ay_r;
      REG_B_X: prdata = bx_r;
      REG_B_Y: prdata = by_r;
    endcase
  end

  always_comb begin
    l = (ax_r < bx_r) ? ax_r : bx_r;
    r = (ax_r < bx_r) ? bx_r : ax_r;
    b = (ay_r < by_r) ? ay_r : by_r;
    t = (ay_r < by_r) ? by_r : ay_r;
  end

  assign co       = (c0_r != OC_INSIDE) ? c0_r : c1_r;
  assign acc      = ((c0_r | c1_r) == OC_INSIDE);
  assign finish   = acc || ((c0_r & c1_r) != OC_INSIDE) ||
                    (pass_r == PASS_BITS'(MAX_PASSES));
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CODE;
      ST_CODE:  state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = finish ? ST_DONE : ST_MUL;
      ST_MUL:   state_nxt = ST_ABS;
      ST_ABS:   state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_SETUP;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    div_start = (state_r == ST_ABS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  assign prod = da_r * dm_r;
  assign pmag = p_r[PROD_BITS-1] ? (~p_r + 1'b1) : p_r;
  assign dmag = db_r[W-1] ? W'(-db_r) : W'(db_r);

  lsrc_div #(.NUM_BITS(PROD_BITS), .DEN_BITS(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (pmag),
    .den   (dmag),
    .quo   (quo),
    .done  (div_done)
  );

  always_comb begin
    qadd = dzero_r ? '0 : (qneg_r ? C'(-quo[C-1:0]) : quo[C-1:0]);
    sum  = a_r + qadd;
    nx   = vert_r ? sum : fix_r;
    ny   = vert_r ? fix_r : sum;
    nc   = outcode(nx, ny, l, r, b, t);
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        x0_r <= in_data.start_x;
        y0_r <= in_data.start_y;
        x1_r <= in_data.end_x;
        y1_r <= in_data.end_y;
        pass_r <= '0;
        n_r <= '0;
        px_r[0] <= '0; px_r[1] <= '0;
        py_r[0] <= '0; py_r[1] <= '0;
      end
      ST_CODE: begin
        c0_r <= outcode(x0_r, y0_r, l, r, b, t);
        c1_r <= outcode(x1_r, y1_r, l, r, b, t);
      end
      ST_SETUP: begin
        sel0_r <= (c0_r != OC_INSIDE);
        if ((co & (OC_TOP | OC_BOTTOM)) != OC_INSIDE) begin
          vert_r <= 1'b1;
          a_r    <= x0_r;
          fix_r  <= ((co & OC_TOP) != OC_INSIDE) ? t : b;
          da_r   <= {x1_r[C-1], x1_r} - {x0_r[C-1], x0_r};
          dm_r   <= ((co & OC_TOP) != OC_INSIDE) ? ({t[C-1], t} - {y0_r[C-1], y0_r})
                                                : ({b[C-1], b} - {y0_r[C-1], y0_r});
          db_r   <= {y1_r[C-1], y1_r} - {y0_r[C-1], y0_r};
        end else begin
          vert_r <= 1'b0;
          a_r    <= y0_r;
          fix_r  <= ((co & OC_RIGHT) != OC_INSIDE) ? r : l;
          da_r   <= {y1_r[C-1], y1_r} - {y0_r[C-1], y0_r};
          dm_r   <= ((co & OC_RIGHT) != OC_INSIDE) ? ({r[C-1], r} - {x0_r[C-1], x0_r})
                                                  : ({l[C-1], l} - {x0_r[C-1], x0_r});
          db_r   <= {x1_r[C-1], x1_r} - {x0_r[C-1], x0_r};
        end
      end
      ST_MUL: p_r <= prod[PROD_BITS-1:0];
      ST_ABS: begin
        qneg_r  <= p_r[PROD_BITS-1] ^ db_r[W-1];
        dzero_r <= (db_r == '0);
      end
      ST_FIN: begin
        pass_r <= pass_r + 1'b1;
        if (sel0_r) begin
          x0_r <= nx; y0_r <= ny; c0_r <= nc;
        end else begin
          x1_r <= nx; y1_r <= ny; c1_r <= nc;
        end
        if (nc == OC_INSIDE && n_r != 2'd2) begin
          px_r[n_r[0]] <= nx;
          py_r[n_r[0]] <= ny;
          n_r <= n_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_r.point_count <= acc ? n_r : 2'd0;
      out_r.first_x     <= acc ? px_r[0] : '0;
      out_r.first_y     <= acc ? py_r[0] : '0;
      out_r.second_x    <= acc ? px_r[1] : '0;
      out_r.second_y    <= acc ? py_r[1] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> pass_r <= PASS_BITS'(MAX_PASSES))
    else $error("pass count beyond limit");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside divide state");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.point_count != 2'd3)
    else $error("point count out of range");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.point_count == 2'd0 |->
      out_r.first_x == '0 && out_r.first_y == '0 &&
      out_r.second_x == '0 && out_r.second_y == '0)
    else $error("empty result carries points");

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the segment clipper: directed and random segments
module tb_top;
  import lsrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic psel, penable, pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [COORD_BITS-1:0] pwdata;
  logic [COORD_BITS-1:0] prdata;
  logic pready;

  coord_t rect_ax, rect_ay, rect_bx, rect_by;
  out_t clip_expected_q[$];
  int err_cnt = 0;
  bit stall_on;

  line_segment_rect_clip dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [3:0] region_code(longint x, longint y, longint l, longint r,
                                             longint b, longint t);
    logic [3:0] c;
    c = OC_INSIDE;
    if (x < l) c |= OC_LEFT;
    else if (x > r) c |= OC_RIGHT;
    if (y < b) c |= OC_BOTTOM;
    else if (y > t) c |= OC_TOP;
    return c;
  endfunction

  function automatic longint edge_cross(longint a, longint da, longint dm, longint db);
    logic [63:0] p, pm, dmag, q, s;
    logic pneg, dneg;
    p = da * dm;
    pneg = p[63];
    dneg = db < 0;
    pm = pneg ? -p : p;
    dmag = dneg ? -db : db;
    q = (dmag == 0) ? 64'd0 : pm / dmag;
    if (pneg != dneg) q = -q;
    s = a + q;
    return longint'(coord_t'(s[31:0]));
  endfunction

  function automatic out_t clip_segment(in_t seg);
    out_t res;
    longint l, r, b, t, x0, y0, x1, y1, x, y;
    longint px[2], py[2];
    logic [3:0] c0, c1, co;
    int n;
    bit ok;
    l = (rect_ax < rect_bx) ? rect_ax : rect_bx;
    r = (rect_ax < rect_bx) ? rect_bx : rect_ax;
    b = (rect_ay < rect_by) ? rect_ay : rect_by;
    t = (rect_ay < rect_by) ? rect_by : rect_ay;
    x0 = seg.start_x; y0 = seg.start_y; x1 = seg.end_x; y1 = seg.end_y;
    c0 = region_code(x0, y0, l, r, b, t);
    c1 = region_code(x1, y1, l, r, b, t);
    px = '{0, 0}; py = '{0, 0};
    n = 0; ok = 0;
    for (int pass = 0; pass <= MAX_PASSES; pass++) begin
      if ((c0 | c1) == 0) begin
        ok = 1;
        break;
      end
      if ((c0 & c1) != 0 || pass == MAX_PASSES) break;
      co = (c0 != 0) ? c0 : c1;
      if (co & OC_TOP) begin
        x = edge_cross(x0, x1 - x0, t - y0, y1 - y0); y = t;
      end else if (co & OC_BOTTOM) begin
        x = edge_cross(x0, x1 - x0, b - y0, y1 - y0); y = b;
      end else if (co & OC_RIGHT) begin
        y = edge_cross(y0, y1 - y0, r - x0, x1 - x0); x = r;
      end else begin
        y = edge_cross(y0, y1 - y0, l - x0, x1 - x0); x = l;
      end
      if (c0 != 0) begin
        x0 = x; y0 = y;
        c0 = region_code(x0, y0, l, r, b, t);
        if (c0 == OC_INSIDE && n < 2) begin
          px[n] = x; py[n] = y; n++;
        end
      end else begin
        x1 = x; y1 = y;
        c1 = region_code(x1, y1, l, r, b, t);
        if (c1 == OC_INSIDE && n < 2) begin
          px[n] = x; py[n] = y; n++;
        end
      end
    end
    if (!ok) begin
      n = 0; px = '{0, 0}; py = '{0, 0};
    end
    res.point_count = n[1:0];
    res.first_x = px[0][31:0];
    res.first_y = py[0][31:0];
    res.second_x = px[1][31:0];
    res.second_y = py[1][31:0];
    return res;
  endfunction

  task automatic wait_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_segment(in_t seg, bit gaps = 1);
    if (gaps && stall_on) wait_gap();
    in_valid <= 1'b1;
    in_data <= seg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    clip_expected_q = {clip_expected_q, clip_segment(seg)};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (clip_expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_corner(logic [1:0] idx, coord_t val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_A_X: rect_ax = val;
      REG_A_Y: rect_ay = val;
      REG_B_X: rect_bx = val;
      default: rect_by = val;
    endcase
  endtask

  task automatic set_rect(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    drain();
    write_corner(REG_A_X, ax);
    write_corner(REG_A_Y, ay);
    write_corner(REG_B_X, bx);
    write_corner(REG_B_Y, by);
  endtask

  function automatic coord_t rand_coord(int span);
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return coord_t'($urandom_range(0, 2 * span) - span);
    endcase
  endfunction

  task automatic test_directed();
    in_t s;
    set_rect(-32'sd65536, 32'sd131072, 32'sd262144, -32'sd196608);
    s = '{32'sd0, 32'sd0, 32'sd65536, 32'sd65536}; send_segment(s);
    s = '{-32'sd655360, 32'sd0, 32'sd655360, 32'sd0}; send_segment(s);
    s = '{32'sd0, -32'sd655360, 32'sd0, 32'sd655360}; send_segment(s);
    s = '{-32'sd655360, 32'sd0, -32'sd400000, 32'sd1}; send_segment(s);
    s = '{-32'sd655360, -32'sd655360, 32'sd655360, 32'sd655360}; send_segment(s);
    s = '{32'sd0, 32'sd0, 32'sd655360, 32'sd655360}; send_segment(s);
    s = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff}; send_segment(s);
    s = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff}; send_segment(s);
    s = '{-32'sd600000, 32'sd400000, 32'sd600000, -32'sd500000}; send_segment(s);
    s = '{32'sd700000, 32'sd0, 32'sd700000, 32'sd1}; send_segment(s);
    s = '{-32'sd200000, 32'sd300000, 32'sd500000, -32'sd100000}; send_segment(s);
    s = '{32'sd262144, 32'sd131072, -32'sd65536, -32'sd196608}; send_segment(s);
    set_rect(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    s = '{32'sd0, 32'sd0, 32'sd5, 32'sd5}; send_segment(s);
    s = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000}; send_segment(s);
    set_rect(32'sd0, 32'sd0, 32'sd0, 32'sd0);
    s = '{-32'sd10, -32'sd10, 32'sd10, 32'sd10}; send_segment(s);
    s = '{32'sd0, 32'sd0, 32'sd0, 32'sd0}; send_segment(s);
    s = '{-32'sd10, 32'sd0, 32'sd10, 32'sd0}; send_segment(s);
  endtask

  task automatic test_random(int count, int span);
    in_t s;
    coord_t ax, ay;
    ax = rand_coord(span);
    ay = rand_coord(span);
    set_rect(ax, ay, ax + coord_t'($urandom_range(0, span)),
             ay - coord_t'($urandom_range(0, span)));
    repeat (count) begin
      s.start_x = rand_coord(4 * span); s.start_y = rand_coord(4 * span);
      s.end_x = rand_coord(4 * span); s.end_y = rand_coord(4 * span);
      send_segment(s);
    end
  endtask

  task automatic test_back_to_back();
    in_t s;
    stall_on = 0;
    repeat (40) begin
      s = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)};
      send_segment(s, 0);
    end
    drain();
    stall_on = 1;
  endtask

  // results are compared against the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (clip_expected_q.size() == 0) begin
        $error("result item with no prediction");
        err_cnt++;
      end else begin
        want = clip_expected_q.pop_front();
        if (out_data.point_count !== want.point_count) begin
          $error("point_count exp %0d got %0d", want.point_count, out_data.point_count);
          err_cnt++;
        end
        if (out_data.first_x !== want.first_x) begin
          $error("first_x exp %0d got %0d", want.first_x, out_data.first_x);
          err_cnt++;
        end
        if (out_data.first_y !== want.first_y) begin
          $error("first_y exp %0d got %0d", want.first_y, out_data.first_y);
          err_cnt++;
        end
        if (out_data.second_x !== want.second_x) begin
          $error("second_x exp %0d got %0d", want.second_x, out_data.second_x);
          err_cnt++;
        end
        if (out_data.second_y !== want.second_y) begin
          $error("second_y exp %0d got %0d", want.second_y, out_data.second_y);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || !stall_on) out_stall <= 1'b0;
    else if ($urandom_range(0, 49) == 0) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 5) != 0) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    stall_on = 1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rect_ax = 0; rect_ay = 0; rect_bx = 0; rect_by = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_back_to_back();
    for (int k = 0; k < 6; k++) test_random(100, 1 << (10 + 3 * k));
    drain();
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
